FILE: rtl/pba_pkg.sv
// Package for the page bitmap allocator: command and status codes, sequencer
// states. No dependencies.
`default_nettype none
package pba_pkg;
  localparam int unsigned ADDR_W  = 52;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned CEIL_W  = 53;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned STAT_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_BELOW = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_NOMEM   = 3'd1,
    ST_BADADDR = 3'd2,
    ST_BELOW   = 3'd3,
    ST_PASTEND = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DECODE, S_CHECK, S_SCAN_RD, S_SCAN, S_BELOW_RD, S_BELOW,
    S_MARK_RD, S_MARK, S_DONE
  } state_t;

  localparam logic [0:0] REG_BASE  = 1'b0;
  localparam logic [0:0] REG_COUNT = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/pba_if.sv
// Valid/ready channel interfaces for the page bitmap allocator.
// Depends on pba_pkg.
`default_nettype none
interface pba_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [pba_pkg::CMD_W-1:0]     command;
  logic [pba_pkg::CNT_W-1:0]     page_total;
  logic [pba_pkg::ADDR_W-1:0]    address;
  logic [pba_pkg::CEIL_W-1:0]    ceiling;
  modport source (output valid, command, page_total, address, ceiling, input ready);
  modport sink   (input valid, command, page_total, address, ceiling, output ready);
endinterface

interface pba_res_if;
  logic                          valid;
  logic                          ready;
  logic [pba_pkg::STAT_W-1:0]    status;
  logic [pba_pkg::ADDR_W-1:0]    result_address;
  logic [pba_pkg::CNT_W-1:0]     free_count;
  modport source (output valid, status, result_address, free_count, input ready);
  modport sink   (input valid, status, result_address, free_count, output ready);
endinterface

interface pba_cfg_if;
  logic                          valid;
  logic                          ready;
  logic                          index;
  logic [63:0]                   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/page_bitmap_allocator.sv
// Top level of the page bitmap allocator: sequencer, used map memory and the
// shared page counter / address adder. Depends on pba_pkg and pba_if.
//
//  channel  dir  contents
//  cmd      in   command, page_total, address, ceiling
//  res      out  status, result_address, free_count
//  cfg      in   index (0 base_address, 1 page_count), data
//
// The used map is a one-bit-wide memory with a single port, so every page
// inspected takes a read state and a decide state, and every page marked
// takes a read state and a mark state. A command passes through decode and
// check, then the scan or mark states, then done. After reset a clearing pass
// writes every entry to used, one a cycle, with both input channels not
// ready. The result sits in an output register; while it waits the next word
// is not taken, and a new word can be accepted in the cycle after the result
// is taken.
`default_nettype none
module page_bitmap_allocator #(
  parameter int unsigned MAX_PAGES  = 4096,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  wire logic clk,
  input  wire logic rst,
  pba_cmd_if.sink   cmd,
  pba_res_if.source res,
  pba_cfg_if.sink   cfg
);
  localparam int unsigned IDX_W = $clog2(MAX_PAGES);
  localparam int unsigned PC_W  = $clog2(MAX_PAGES + 1);
  localparam int unsigned W     = 64;

  pba_pkg::state_t state, state_next;

  // One used bit per page, held in a single-ported memory.
  logic used_map [MAX_PAGES];
  logic [IDX_W-1:0] mem_addr;
  logic             mem_we;
  logic             mem_wbit;

  logic [W-1:0] base_address;
  logic [pba_pkg::CNT_W-1:0] page_count;
  logic [pba_pkg::CNT_W-1:0] free_held;
  logic [IDX_W-1:0] hint;

  logic [pba_pkg::CMD_W-1:0]  op;
  logic [pba_pkg::CNT_W-1:0]  want;
  logic [W-1:0]               addr_q;
  logic [W-1:0]               ceil_q;
  logic [PC_W-1:0]            total;
  logic [PC_W-1:0]            pos;     // current page
  logic [PC_W-1:0]            scanned;
  logic [pba_pkg::CNT_W-1:0]  run;
  logic [PC_W-1:0]            start;
  logic [pba_pkg::CNT_W-1:0]  k;
  logic                       taking;  // marking pages used (else freeing)
  logic                       bit_q;
  logic [pba_pkg::STAT_W-1:0] stat_q;
  logic [pba_pkg::ADDR_W-1:0] raddr_q;
  logic                       res_valid;
  logic [W-1:0]               sum;     // shared address adder
  logic [W:0]                 idx_end;
  logic                       past_ceil;

  logic [W-1:0] page_off;
  always_comb begin
    page_off = W'(pos) << PAGE_SHIFT;
    sum = base_address + page_off;
  end

  // The page at pos does not lie wholly below the ceiling.
  assign past_ceil = ({1'b0, sum} + (W+1)'(64'd1 << PAGE_SHIFT)) > {1'b0, ceil_q};

  always_comb begin
    total = (W'(page_count) > W'(MAX_PAGES)) ? PC_W'(MAX_PAGES) : PC_W'(page_count);
  end

  assign cfg.ready = (state == pba_pkg::S_IDLE) && !res_valid;
  assign cmd.ready = (state == pba_pkg::S_IDLE) && !res_valid;
  assign res.valid = res_valid;
  assign res.status = stat_q;
  assign res.result_address = raddr_q;
  assign res.free_count = free_held;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pba_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  logic [W-1:0] freeidx;
  assign freeidx = (addr_q - base_address) >> PAGE_SHIFT;
  assign idx_end = {1'b0, freeidx} + (W+1)'(want);

  always_comb begin
    state_next = state;
    unique case (state)
      pba_pkg::S_INIT:     if (pos == PC_W'(MAX_PAGES - 1)) state_next = pba_pkg::S_IDLE;
      pba_pkg::S_IDLE:     if (cmd.valid && cmd.ready) state_next = pba_pkg::S_DECODE;
      pba_pkg::S_DECODE:   state_next = pba_pkg::S_CHECK;
      pba_pkg::S_CHECK: begin
        state_next = pba_pkg::S_DONE;
        case (op)
          pba_pkg::CMD_ALLOC:
            if (want != 0 && want <= pba_pkg::CNT_W'(total))
              state_next = pba_pkg::S_SCAN_RD;
          pba_pkg::CMD_BELOW: if (total != 0) state_next = pba_pkg::S_BELOW_RD;
          pba_pkg::CMD_FREE:
            if (!(addr_q == 0 || addr_q[PAGE_SHIFT-1:0] != 0 || addr_q < base_address
                  || idx_end > (W+1)'(total)) && want != 0)
              state_next = pba_pkg::S_MARK_RD;
          default: state_next = pba_pkg::S_DONE;
        endcase
      end
      pba_pkg::S_SCAN_RD:  state_next = (scanned < total) ? pba_pkg::S_SCAN : pba_pkg::S_DONE;
      pba_pkg::S_SCAN: begin
        if (!bit_q && run + 1'b1 == want) state_next = pba_pkg::S_MARK_RD;
        else state_next = pba_pkg::S_SCAN_RD;
      end
      pba_pkg::S_BELOW_RD: state_next = pba_pkg::S_BELOW;
      pba_pkg::S_BELOW: begin
        if (past_ceil) state_next = pba_pkg::S_DONE;
        else if (!bit_q) state_next = pba_pkg::S_MARK_RD;
        else if (pos + 1'b1 >= total) state_next = pba_pkg::S_DONE;
        else state_next = pba_pkg::S_BELOW_RD;
      end
      pba_pkg::S_MARK_RD:  state_next = pba_pkg::S_MARK;
      pba_pkg::S_MARK:     state_next = (k + 1'b1 >= want) ? pba_pkg::S_DONE : pba_pkg::S_MARK_RD;
      pba_pkg::S_DONE:     state_next = pba_pkg::S_IDLE;
      default:             state_next = pba_pkg::S_IDLE;
    endcase
  end

  logic [IDX_W-1:0] pidx;
  assign pidx = pos[IDX_W-1:0];

  // Map port: the clearing pass writes ones, marking writes the new bit only
  // when it changes. The mark read looks ahead at start + k, since pos only
  // follows it in the next cycle.
  always_comb begin
    mem_addr = pidx;
    mem_we   = 1'b0;
    mem_wbit = 1'b1;
    if (state == pba_pkg::S_MARK_RD) mem_addr = IDX_W'(start + PC_W'(k));
    if (state == pba_pkg::S_INIT) begin
      mem_we = 1'b1;
    end else if (state == pba_pkg::S_MARK && pos < total && taking != bit_q) begin
      mem_we   = 1'b1;
      mem_wbit = taking;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) used_map[mem_addr] <= mem_wbit;
    bit_q <= used_map[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_held    <= '0;
      hint         <= '0;
      base_address <= '0;
      page_count   <= pba_pkg::CNT_W'(4096);
      res_valid    <= 1'b0;
      pos          <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == pba_pkg::REG_BASE) base_address <= {12'd0, cfg.data[51:0]};
        else page_count <= cfg.data[pba_pkg::CNT_W-1:0];
      end
      if (res_valid && res.ready) res_valid <= 1'b0;
      unique case (state)
        pba_pkg::S_INIT: pos <= pos + 1'b1;
        pba_pkg::S_IDLE: if (cmd.valid && cmd.ready) begin
          op     <= cmd.command;
          want   <= cmd.page_total;
          addr_q <= {12'd0, cmd.address};
          ceil_q <= {11'd0, cmd.ceiling};
        end
        pba_pkg::S_DECODE: begin
          stat_q  <= pba_pkg::ST_NOMEM;
          raddr_q <= '0;
          run     <= '0;
          scanned <= '0;
          k       <= '0;
          if (op == pba_pkg::CMD_ALLOC) begin
            pos <= (PC_W'(hint) < total) ? PC_W'(hint) : '0;
            taking <= 1'b1;
          end else if (op == pba_pkg::CMD_BELOW) begin
            pos <= '0;
            taking <= 1'b1;
          end else begin
            taking <= 1'b0;
          end
        end
        pba_pkg::S_CHECK: begin
          if (op == pba_pkg::CMD_FREE) begin
            if (addr_q == 0 || addr_q[PAGE_SHIFT-1:0] != 0) stat_q <= pba_pkg::ST_BADADDR;
            else if (addr_q < base_address) stat_q <= pba_pkg::ST_BELOW;
            else if (idx_end > (W+1)'(total)) stat_q <= pba_pkg::ST_PASTEND;
            else stat_q <= pba_pkg::ST_OK;
            start <= PC_W'(freeidx);
          end
        end
        pba_pkg::S_SCAN: begin
          if (bit_q) begin
            run <= '0;
          end else if (run + 1'b1 == want) begin
            start   <= pos + 1'b1 - PC_W'(want);
            hint    <= (pos + 1'b1 < total) ? IDX_W'(pos + 1'b1) : '0;
            stat_q  <= pba_pkg::ST_OK;
          end else begin
            run <= run + 1'b1;
          end
          if (bit_q || run + 1'b1 != want) begin
            scanned <= scanned + 1'b1;
            if (pos + 1'b1 >= total) begin
              pos <= '0;
              run <= '0;
            end else begin
              pos <= pos + 1'b1;
            end
          end
        end
        pba_pkg::S_BELOW: begin
          if (!past_ceil) begin
            if (!bit_q) begin
              start   <= pos;
              stat_q  <= pba_pkg::ST_OK;
              raddr_q <= sum[pba_pkg::ADDR_W-1:0];
            end else begin
              pos <= pos + 1'b1;
            end
          end
        end
        pba_pkg::S_MARK_RD: pos <= start + PC_W'(k);
        pba_pkg::S_MARK: begin
          if (op == pba_pkg::CMD_ALLOC && k == 0) raddr_q <= sum[pba_pkg::ADDR_W-1:0];
          if (pos < total) begin
            if (taking && !bit_q) free_held <= free_held - 1'b1;
            else if (!taking && bit_q) free_held <= free_held + 1'b1;
          end
          k <= k + 1'b1;
        end
        pba_pkg::S_DONE: res_valid <= 1'b1;
        default: ;
      endcase
      if (state == pba_pkg::S_BELOW && op == pba_pkg::CMD_BELOW) want <= pba_pkg::CNT_W'(1);
    end
  end
endmodule
`default_nettype wire
